>>> rtl/core/ffaa_pkg.sv
package ffaa_pkg;

  // fixed field widths
  localparam int unsigned HdrW   = 13;
  localparam int unsigned SizeW  = 16;
  localparam int unsigned WordsW = 14;
  localparam int unsigned EndW   = 15;
  localparam int unsigned CmpW   = 20;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ZERO_SIZE  = 3'd1,
    ST_NO_SPACE   = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_BAD_HANDLE = 3'd4,
    ST_TABLE_FULL = 3'd5
  } status_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_ARENA_BYTES = 2'd0
  } reg_e;

  // classified request
  typedef struct packed {
    op_e               op;
    logic              zero;
    logic [SizeW-1:0]  req_bytes;
    logic [WordsW-1:0] req_words;
    logic [15:0]       handle;
  } item_t;

  // one table entry
  typedef struct packed {
    logic [HdrW-1:0]  hdr;
    logic [SizeW-1:0] size;
  } entry_t;

  // bytes rounded up to 8-byte words
  function automatic logic [WordsW-1:0] word_count(input logic [SizeW-1:0] bytes);
    logic [SizeW:0] sum;
    sum = {1'b0, bytes} + (SizeW+1)'(7);
    return sum[SizeW:3];
  endfunction

endpackage

>>> rtl/core/ffaa_req_if.sv
interface ffaa_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] request_bytes;
  logic [15:0] handle;

  modport source (output valid, cmd, request_bytes, handle, input ready);
  modport sink (input valid, cmd, request_bytes, handle, output ready);
endinterface

>>> rtl/core/ffaa_rsp_if.sv
interface ffaa_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] data_offset;
  logic [6:0]  blocks_in_use;

  modport source (output valid, status, data_offset, blocks_in_use, input ready);
  modport sink (input valid, status, data_offset, blocks_in_use, output ready);
endinterface

>>> rtl/core/first_fit_arena_allocator.sv
// First-fit arena allocator. Requests (allocate or free) are taken into a two-beat
// front queue and carried out one at a time by a sequencer over the block table,
// a memory of MAX_BLOCKS entries with one read and one write port, kept in address
// order. Each table entry visited is read, then evaluated, and each entry moved by
// an insert or a remove is read and then written back one place over; a request
// rejected up front goes straight to the response state. The result is held in an
// output register, so new requests are queued while a result waits. The table
// needs no clearing after reset. Write arena_bytes at byte address 0 of the APB
// port only while idle.
module first_fit_arena_allocator #(
  parameter int unsigned MAX_BLOCKS      = 64,
  parameter int unsigned ARENA_ADDR_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  ffaa_req_if.sink    req_i,
  ffaa_rsp_if.source  rsp_o
);
  import ffaa_pkg::*;

  logic [15:0] arena_bytes_q;
  item_t       item;
  logic        item_valid, item_pop;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == REG_ARENA_BYTES) ? {16'b0, arena_bytes_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_bytes_q <= 16'hFFFF;
    end else if (psel && penable && pwrite && paddr == REG_ARENA_BYTES) begin
      arena_bytes_q <= pwdata[15:0];
    end
  end

  ffaa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  ffaa_back #(
    .MAX_BLOCKS      (MAX_BLOCKS),
    .ARENA_ADDR_BITS (ARENA_ADDR_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .arena_bytes_i (arena_bytes_q),
    .item_i        (item),
    .item_valid_i  (item_valid),
    .item_pop_o    (item_pop),
    .rsp_o         (rsp_o)
  );

endmodule

>>> rtl/core/ffaa_front.sv
module ffaa_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  ffaa_req_if.sink        req_i,
  output ffaa_pkg::item_t item_o,
  output logic            item_valid_o,
  input  logic            item_pop_i
);
  import ffaa_pkg::*;

  item_t      q_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  item_t      cls;
  logic       push;

  // classify the incoming beat
  always_comb begin
    cls.op        = req_i.cmd ? OP_FREE : OP_ALLOC;
    cls.zero      = (req_i.request_bytes == '0);
    cls.req_bytes = req_i.request_bytes;
    cls.req_words = word_count(req_i.request_bytes);
    cls.handle    = req_i.handle;
  end

  assign req_i.ready  = (count_q != 2'd2);
  assign push         = req_i.valid && req_i.ready;
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = q_q[rd_ptr_q];

  // payload slots
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (item_pop_i) rd_ptr_q <= ~rd_ptr_q;
      case ({push, item_pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> rtl/core/ffaa_back.sv
module ffaa_back #(
  parameter int unsigned MAX_BLOCKS      = 64,
  parameter int unsigned ARENA_ADDR_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [15:0]     arena_bytes_i,
  input  ffaa_pkg::item_t item_i,
  input  logic            item_valid_i,
  output logic            item_pop_o,
  ffaa_rsp_if.source      rsp_o
);
  import ffaa_pkg::*;

  localparam int unsigned IdxW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1);
  localparam logic [15:0] OffMask =
    (ARENA_ADDR_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << ARENA_ADDR_BITS) - 32'd1);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_EV, S_SH_RD, S_SH_WR, S_INS, S_RESP
  } state_e;

  state_e           state_q;
  entry_t           mem [MAX_BLOCKS];
  entry_t           rdata_q;
  logic [IdxW-1:0]  raddr;
  logic             we;
  logic [IdxW-1:0]  waddr;
  entry_t           wdata;

  item_t            cur_q;
  logic [CntW-1:0]  total_q;
  logic [IdxW-1:0]  idx_q, src_q, dst_q;
  logic [CntW-1:0]  pos_q;
  logic [EndW-1:0]  prev_end_q, w_q;
  status_e          status_q;
  logic             out_valid_q;
  status_e          out_status_q;
  logic [15:0]      out_offset_q;
  logic [6:0]       out_blocks_q;

  // entry evaluation
  logic [EndW-1:0]  ent_end;
  logic             fit_first, fit_gap, fit_tail, hit, last;
  logic [HdrW:0]    hdr_p2;
  logic [HdrW-1:0]  w_p2;

  always_comb begin
    ent_end   = {2'b0, rdata_q.hdr} + EndW'(2) + {1'b0, word_count(rdata_q.size)};
    fit_first = $signed({4'b0, rdata_q.hdr, 3'b0})
                >= $signed({4'b0, cur_q.req_bytes} + CmpW'(32));
    fit_gap   = $signed({7'b0, rdata_q.hdr} - {5'b0, prev_end_q})
                >= $signed({6'b0, cur_q.req_words} + CmpW'(2));
    fit_tail  = $signed({4'b0, arena_bytes_i} - {2'b0, ent_end, 3'b0})
                >= $signed({4'b0, cur_q.req_bytes} + CmpW'(16));
    hdr_p2    = {1'b0, rdata_q.hdr} + (HdrW+1)'(2);
    hit       = ({hdr_p2, 3'b0} == {1'b0, cur_q.handle});
    last      = ((CntW'(idx_q) + CntW'(1)) == total_q);
    w_p2      = w_q[HdrW-1:0] + HdrW'(2);
  end

  // table port control
  always_comb begin
    raddr = (state_q == S_RD) ? idx_q : src_q;
    we    = 1'b0;
    waddr = dst_q;
    wdata = rdata_q;
    if (state_q == S_SH_WR) begin
      we = 1'b1;
    end else if (state_q == S_INS) begin
      we         = 1'b1;
      waddr      = pos_q[IdxW-1:0];
      wdata.hdr  = w_q[HdrW-1:0];
      wdata.size = cur_q.req_bytes;
    end
  end

  // block table
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  assign item_pop_o          = (state_q == S_IDLE) && item_valid_i;
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.data_offset   = out_offset_q;
  assign rsp_o.blocks_in_use = out_blocks_q;

  // request sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      total_q      <= '0;
      out_valid_q  <= 1'b0;
      cur_q        <= '0;
      idx_q        <= '0;
      src_q        <= '0;
      dst_q        <= '0;
      pos_q        <= '0;
      prev_end_q   <= '0;
      w_q          <= '0;
      status_q     <= ST_OK;
      out_status_q <= ST_OK;
      out_offset_q <= '0;
      out_blocks_q <= '0;
    end else begin
      if (rsp_o.valid && rsp_o.ready && state_q != S_RESP) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (item_valid_i) begin
            cur_q    <= item_i;
            idx_q    <= '0;
            if (item_i.op == OP_ALLOC) begin
              if (item_i.zero) begin
                status_q <= ST_ZERO_SIZE;
                state_q  <= S_RESP;
              end else if (total_q == CntW'(MAX_BLOCKS)) begin
                status_q <= ST_TABLE_FULL;
                state_q  <= S_RESP;
              end else if (total_q == '0) begin
                if ($signed({4'b0, item_i.req_bytes})
                    > $signed({4'b0, arena_bytes_i} - CmpW'(32))) begin
                  status_q <= ST_NO_SPACE;
                  state_q  <= S_RESP;
                end else begin
                  status_q <= ST_OK;
                  w_q      <= EndW'(2);
                  pos_q    <= '0;
                  state_q  <= S_INS;
                end
              end else begin
                status_q <= ST_OK;
                state_q  <= S_RD;
              end
            end else begin
              if (total_q == '0) begin
                status_q <= ST_EMPTY;
                state_q  <= S_RESP;
              end else begin
                status_q <= ST_OK;
                state_q  <= S_RD;
              end
            end
          end
        end
        S_RD: state_q <= S_EV;
        S_EV: begin
          if (cur_q.op == OP_ALLOC) begin
            if ((idx_q == '0) ? fit_first : fit_gap) begin
              w_q   <= (idx_q == '0) ? EndW'(2) : prev_end_q;
              pos_q <= CntW'(idx_q);
              if (CntW'(idx_q) == total_q) begin
                state_q <= S_INS;
              end else begin
                dst_q   <= IdxW'(total_q);
                src_q   <= IdxW'(total_q - CntW'(1));
                state_q <= S_SH_RD;
              end
            end else if (last) begin
              if (fit_tail) begin
                w_q     <= ent_end;
                pos_q   <= total_q;
                state_q <= S_INS;
              end else begin
                status_q <= ST_NO_SPACE;
                state_q  <= S_RESP;
              end
            end else begin
              prev_end_q <= ent_end;
              idx_q      <= idx_q + IdxW'(1);
              state_q    <= S_RD;
            end
          end else begin
            if (hit) begin
              pos_q <= CntW'(idx_q);
              if (last) begin
                total_q <= total_q - CntW'(1);
                state_q <= S_RESP;
              end else begin
                dst_q   <= idx_q;
                src_q   <= idx_q + IdxW'(1);
                state_q <= S_SH_RD;
              end
            end else if (last) begin
              status_q <= ST_BAD_HANDLE;
              state_q  <= S_RESP;
            end else begin
              idx_q   <= idx_q + IdxW'(1);
              state_q <= S_RD;
            end
          end
        end
        S_SH_RD: state_q <= S_SH_WR;
        S_SH_WR: begin
          if (cur_q.op == OP_ALLOC) begin
            if (CntW'(src_q) == pos_q) begin
              state_q <= S_INS;
            end else begin
              dst_q   <= src_q;
              src_q   <= src_q - IdxW'(1);
              state_q <= S_SH_RD;
            end
          end else begin
            if ((CntW'(src_q) + CntW'(1)) == total_q) begin
              total_q <= total_q - CntW'(1);
              state_q <= S_RESP;
            end else begin
              dst_q   <= src_q;
              src_q   <= src_q + IdxW'(1);
              state_q <= S_SH_RD;
            end
          end
        end
        S_INS: begin
          total_q <= total_q + CntW'(1);
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= status_q;
            out_offset_q <= (status_q == ST_OK && cur_q.op == OP_ALLOC)
                            ? ({w_p2, 3'b0} & OffMask) : 16'd0;
            out_blocks_q <= 7'(total_q);
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> tb/first_fit_arena_allocator_tb.sv
`timescale 1ns / 100ps

module first_fit_arena_allocator_tb;
  import ffaa_pkg::*;

  localparam int unsigned MaxBlocks = 64;
  localparam int unsigned DrainCycles = 4 * MaxBlocks + 40;

  typedef struct {
    status_e     status;
    logic [15:0] offset;
    logic [6:0]  blocks;
  } alloc_result_t;

  typedef struct {
    logic        cmd;
    logic [15:0] req_bytes;
    logic [15:0] handle;
    bit          typed;
    status_e     status;
    logic [15:0] offset;
    logic [6:0]  blocks;
  } directed_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ffaa_req_if req_if ();
  ffaa_rsp_if rsp_if ();

  first_fit_arena_allocator u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // shadow of the block table
  logic [12:0]   tbl_hdr [MaxBlocks+1];
  logic [15:0]   tbl_size[MaxBlocks+1];
  int unsigned   tbl_total;
  logic [15:0]   arena_size;
  alloc_result_t pending_results[$];

  int unsigned n_errors;
  int unsigned n_mismatch;
  int unsigned n_results;
  int unsigned n_status[6];
  int unsigned max_blocks_seen;
  bit          rsp_no_stall;
  bit          rsp_hold;
  bit          req_no_gap;

  // clock
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic longint words_of(logic [15:0] bytes);
    return longint'((int'(bytes) + 7) >> 3);
  endfunction

  // first-fit placement and unlinking on the shadow table
  function automatic alloc_result_t predict_request(logic cmd, logic [15:0] req_bytes,
                                                    logic [15:0] handle);
    alloc_result_t res;
    longint w;
    longint blk_end;
    int unsigned pos;
    int found;
    res.status = ST_OK;
    res.offset = '0;
    w = -1;
    pos = 0;
    found = -1;
    if (cmd == OP_ALLOC) begin
      if (req_bytes == 0) begin
        res.status = ST_ZERO_SIZE;
      end else if (tbl_total >= MaxBlocks) begin
        res.status = ST_TABLE_FULL;
      end else if (tbl_total == 0) begin
        if (longint'(req_bytes) <= longint'(arena_size) - 32) w = 2;
      end else if ((longint'(tbl_hdr[0]) - 1) * 8 >= longint'(req_bytes) + 24) begin
        w = 2;
      end else begin
        for (int i = 0; i < tbl_total && w < 0; i++) begin
          blk_end = longint'(tbl_hdr[i]) + 2 + words_of(tbl_size[i]);
          if (i + 1 < tbl_total) begin
            if (longint'(tbl_hdr[i+1]) - blk_end >= words_of(req_bytes) + 2) begin
              w = blk_end;
              pos = i + 1;
            end
          end else if (longint'(arena_size) - blk_end * 8 >= longint'(req_bytes) + 16) begin
            w = blk_end;
            pos = i + 1;
          end
        end
      end
      if (res.status == ST_OK && w < 0) res.status = ST_NO_SPACE;
      if (res.status == ST_OK) begin
        for (int i = tbl_total; i > pos; i--) begin
          tbl_hdr[i]  = tbl_hdr[i-1];
          tbl_size[i] = tbl_size[i-1];
        end
        tbl_hdr[pos]  = 13'(w);
        tbl_size[pos] = req_bytes;
        tbl_total++;
        res.offset = 16'((w + 2) * 8);
      end
    end else begin
      if (tbl_total == 0) begin
        res.status = ST_EMPTY;
      end else begin
        for (int i = 0; i < tbl_total; i++) begin
          if (found < 0 && (longint'(tbl_hdr[i]) + 2) * 8 == longint'(handle)) found = i;
        end
        if (found < 0) begin
          res.status = ST_BAD_HANDLE;
        end else begin
          for (int i = found; i + 1 < tbl_total; i++) begin
            tbl_hdr[i]  = tbl_hdr[i+1];
            tbl_size[i] = tbl_size[i+1];
          end
          tbl_total--;
        end
      end
    end
    res.blocks = 7'(tbl_total);
    return res;
  endfunction

  // apb register write, setup then access
  task automatic write_reg(reg_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 2'(idx * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_ARENA_BYTES) arena_size = value[15:0];
  endtask

  // one request beat, then an optional gap
  task automatic send_request(logic cmd, logic [15:0] req_bytes, logic [15:0] handle,
                              bit typed, alloc_result_t typed_res);
    alloc_result_t res;
    int unsigned gap;
    int unsigned r;
    req_if.valid         <= 1'b1;
    req_if.cmd           <= cmd;
    req_if.request_bytes <= req_bytes;
    req_if.handle        <= handle;
    do @(posedge clk_i); while (!req_if.ready);
    res = predict_request(cmd, req_bytes, handle);
    pending_results.insert(pending_results.size(), typed ? typed_res : res);
    r = $urandom_range(0, 99);
    if (req_no_gap || r < 55) gap = 0;
    else if (r < 95) gap = $urandom_range(1, 4);
    else gap = $urandom_range(20, 80);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // random request shaped by the current arena and table fill
  task automatic send_random(int unsigned alloc_pct);
    alloc_result_t none;
    logic [15:0] sz;
    logic [15:0] h;
    int unsigned r;
    int unsigned cap;
    none = '{ST_OK, '0, '0};
    r = $urandom_range(0, 99);
    if (r < alloc_pct) begin
      r = $urandom_range(0, 99);
      cap = (arena_size / 16 > 1) ? arena_size / 16 : 1;
      if (r < 4) sz = 16'd0;
      else if (r < 10) sz = 16'($urandom());
      else if (r < 16) sz = 16'(int'(arena_size) - 32 + $urandom_range(0, 8) - 4);
      else if (r < 60) sz = 16'($urandom_range(1, 64));
      else sz = 16'($urandom_range(1, cap));
      send_request(OP_ALLOC, sz, 16'($urandom()), 1'b0, none);
    end else begin
      r = $urandom_range(0, 99);
      if (tbl_total != 0 && r < 75) begin
        h = 16'((int'(tbl_hdr[$urandom_range(0, tbl_total - 1)]) + 2) * 8);
      end else if (r < 88) begin
        h = 16'($urandom_range(0, 8191) * 8);
      end else begin
        h = 16'($urandom());
      end
      send_request(OP_FREE, 16'($urandom()), h, 1'b0, none);
    end
  endtask

  // response ready with random stalls and one long hold-off
  initial begin
    int unsigned r;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      r = $urandom_range(0, 99);
      if (rsp_hold) begin
        rsp_if.ready <= 1'b0;
        repeat (600) @(posedge clk_i);
        rsp_hold = 1'b0;
      end else if (rsp_no_stall || r < 60) begin
        rsp_if.ready <= 1'b1;
        @(posedge clk_i);
      end else if (r < 95) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end else begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(20, 100)) @(posedge clk_i);
      end
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    alloc_result_t exp_res;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      n_results++;
      if (rsp_if.status < 6) n_status[rsp_if.status]++;
      if (rsp_if.blocks_in_use > max_blocks_seen) max_blocks_seen = rsp_if.blocks_in_use;
      if (pending_results.size() == 0) begin
        n_errors++;
        $display("ERROR: result beat with nothing expected (status %0d)", rsp_if.status);
      end else begin
        exp_res = pending_results.pop_front();
        if (rsp_if.status !== exp_res.status || rsp_if.data_offset !== exp_res.offset ||
            rsp_if.blocks_in_use !== exp_res.blocks) begin
          n_errors++;
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("MISMATCH: exp status %0d offset %0d blocks %0d, got %0d %0d %0d",
                     exp_res.status, exp_res.offset, exp_res.blocks, rsp_if.status,
                     rsp_if.data_offset, rsp_if.blocks_in_use);
        end
      end
    end
  end

  // overall time limit
  initial begin
    #40_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // stimulus
  initial begin
    directed_row_t rows[$];
    alloc_result_t typed_res;
    logic [15:0] arena_plan[6];
    int unsigned alloc_plan[6];

    rows = '{
      '{OP_ALLOC, 16'd0,     16'd0,     1, ST_ZERO_SIZE,  16'd0,  7'd0},
      '{OP_FREE,  16'd0,     16'd32,    1, ST_EMPTY,      16'd0,  7'd0},
      '{OP_ALLOC, 16'd1,     16'hffff,  1, ST_OK,         16'd32, 7'd1},
      '{OP_FREE,  16'hffff,  16'd33,    1, ST_BAD_HANDLE, 16'd0,  7'd1},
      '{OP_FREE,  16'd0,     16'd0,     1, ST_BAD_HANDLE, 16'd0,  7'd1},
      '{OP_FREE,  16'd0,     16'd32,    1, ST_OK,         16'd0,  7'd0},
      '{OP_ALLOC, 16'hffff,  16'd0,     1, ST_NO_SPACE,   16'd0,  7'd0},
      '{OP_ALLOC, 16'd65503, 16'd0,     1, ST_OK,         16'd32, 7'd1},
      '{OP_ALLOC, 16'd1,     16'd0,     1, ST_NO_SPACE,   16'd0,  7'd1},
      '{OP_FREE,  16'd0,     16'd32,    1, ST_OK,         16'd0,  7'd0},
      '{OP_ALLOC, 16'd8,     16'd0,     0, ST_OK,         16'd0,  7'd0},
      '{OP_ALLOC, 16'd8,     16'd0,     0, ST_OK,         16'd0,  7'd0},
      '{OP_ALLOC, 16'd16,    16'd0,     0, ST_OK,         16'd0,  7'd0},
      '{OP_FREE,  16'd0,     16'd56,    0, ST_OK,         16'd0,  7'd0},
      '{OP_ALLOC, 16'd9,     16'd0,     0, ST_OK,         16'd0,  7'd0},
      '{OP_FREE,  16'd0,     16'd32,    0, ST_OK,         16'd0,  7'd0},
      '{OP_ALLOC, 16'd8,     16'd0,     0, ST_OK,         16'd0,  7'd0},
      '{OP_FREE,  16'hffff,  16'hffff,  0, ST_OK,         16'd0,  7'd0},
      '{OP_FREE,  16'd0,     16'd16,    0, ST_OK,         16'd0,  7'd0}
    };
    arena_plan = '{16'd33, 16'd512, 16'd65535, 16'd2048, 16'd200, 16'd0};
    alloc_plan = '{60, 60, 80, 55, 50, 55};
    arena_plan[5] = 16'($urandom_range(33, 65535));

    tbl_total = 0;
    arena_size = 16'd65535;
    n_errors = 0;
    n_mismatch = 0;
    n_results = 0;
    max_blocks_seen = 0;
    rsp_no_stall = 1'b0;
    rsp_hold = 1'b0;
    req_no_gap = 1'b0;
    foreach (n_status[i]) n_status[i] = 0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_if.valid = 1'b0;
    req_if.cmd = OP_ALLOC;
    req_if.request_bytes = '0;
    req_if.handle = '0;

    // reset
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at the reset arena size
    foreach (rows[i]) begin
      typed_res = '{rows[i].status, rows[i].offset, rows[i].blocks};
      send_request(rows[i].cmd, rows[i].req_bytes, rows[i].handle, rows[i].typed, typed_res);
    end

    // random phases, each at its own arena size
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      write_reg(REG_ARENA_BYTES, 32'(arena_plan[p]));
      rsp_no_stall = (p == 3);
      req_no_gap = (p == 3);
      for (int n = 0; n < 300; n++) begin
        // long receiver hold-off while requests keep coming
        if (p == 2 && n == 100) begin
          rsp_hold = 1'b1;
          req_no_gap = 1'b1;
        end
        if (p == 2 && n == 160) req_no_gap = 1'b0;
        // sender waits for every outstanding result
        if (p == 1 && n == 150) begin
          req_if.valid <= 1'b0;
          do @(posedge clk_i); while (pending_results.size() != 0);
        end
        send_random(alloc_plan[p]);
      end
    end

    // drain
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d results: ok %0d, zero size %0d, no space %0d, empty %0d,",
             n_results, n_status[0], n_status[1], n_status[2], n_status[3]);
    $display("bad handle %0d, table full %0d, peak blocks %0d, mismatches %0d",
             n_status[4], n_status[5], max_blocks_seen, n_mismatch);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
